### design/acpb_pkg.sv
// ----------------------------------------------------------------------------
// acpb_pkg: shared types and constants for the antialiased circle blend
// Fixed-point formats, square-root chain sizes, register codes and the
// structures passed between the front end, the root cells and the blender.
// ----------------------------------------------------------------------------
package acpb_pkg;

    // Fraction bits of distance and alpha
    localparam int FRAC_BITS = 8;

    localparam int COORD_W = 12;
    localparam int DIM_W   = 13;
    localparam int RADIUS_W = 10;
    localparam int RGB_W   = 24;
    localparam int COLOR_W = 32;
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 24;

    // dx*dx + dy*dy is below 2 * 4096^2
    localparam int SQ_W  = 2 * COORD_W;
    localparam int D2_W  = SQ_W + 1;

    // Square root of (d2 << 2F): one cell per root bit
    localparam int ROOT_W = (D2_W + 2 * FRAC_BITS + 1) / 2;
    localparam int RAD_W  = 2 * ROOT_W;
    localparam int RAD_PAD_W = RAD_W - D2_W - 2 * FRAC_BITS;
    localparam int REM_W  = ROOT_W + 2;

    // Distance compare width and alpha width (alpha runs 0..2^F)
    localparam int CMP_W   = ROOT_W + 1;
    localparam int ALPHA_W = FRAC_BITS + 1;

    localparam int unsigned ONE_Q = 1 << FRAC_BITS;
    localparam int unsigned C06_Q = ((6 << FRAC_BITS) + 5) / 10;
    localparam int unsigned C18_Q = ((18 << FRAC_BITS) + 5) / 10;

    localparam logic [7:0] ALPHA_BYTE = 8'hFF;

    // Configuration register indexes
    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_CENTER_COL    = 3'd0,
        REG_CENTER_ROW    = 3'd1,
        REG_CIRCLE_RADIUS = 3'd2,
        REG_DRAW_RGB      = 3'd3,
        REG_SCREEN_COLS   = 3'd4,
        REG_SCREEN_ROWS   = 3'd5
    } acpb_reg_t;

    // Configuration seen by the datapath
    typedef struct packed {
        logic [COORD_W-1:0]  center_col;
        logic [COORD_W-1:0]  center_row;
        logic [RADIUS_W-1:0] circle_radius;
        logic [RGB_W-1:0]    draw_rgb;
        logic [DIM_W-1:0]    screen_cols;
        logic [DIM_W-1:0]    screen_rows;
    } acpb_cfg_t;

    // Per-pixel payload riding along the root chain
    typedef struct packed {
        logic             on_screen;
        logic [RGB_W-1:0] dst_rgb;
    } acpb_tag_t;

    // State handed from one root cell to the next
    typedef struct packed {
        logic [REM_W-1:0]  rem;
        logic [ROOT_W-1:0] root;
        logic [RAD_W-1:0]  rad;
        acpb_tag_t         tag;
    } acpb_cell_t;

endpackage

### design/antialiased_circle_pixel_blend.sv
// ----------------------------------------------------------------------------
// antialiased_circle_pixel_blend: antialiased circle edge blend per pixel
// Distance from the circle center by a chain of square-root cells, coverage
// alpha from the radius, and a blend of the draw color over the framebuffer.
//
//  channel  | direction | fields
//  ---------+-----------+------------------------------------------------
//  s_*      | in        | tdata: pixel_col, pixel_row, fb_word
//  m_*      | out       | tdata: blended_color; tuser: write_pixel
//  cfg_*    | in        | cfg_index selects register, cfg_data its value
//
// One pixel per clock sustained while m_tready stays high. The chain runs from
// the front stages through one root cell per distance bit to the blend stages.
// Reset clears all stage valid bits and loads register defaults; no sweep.
// Each stage holds while the next is full; empty stages fill behind a stall.
// Configuration writes are always accepted (cfg_ready is tied high) and registered.
// ----------------------------------------------------------------------------
module antialiased_circle_pixel_blend
    import acpb_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [55:0]            s_tdata,   // pixel_col, pixel_row, fb_word
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [COLOR_W-1:0]     m_tdata,   // blended_color
    output logic                   m_tuser,   // write_pixel
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    acpb_cfg_t  cfg_reg;
    acpb_cfg_t  cfg_next;

    logic       chain_valid [ROOT_W+1];
    logic       chain_ready [ROOT_W+1];
    acpb_cell_t chain_cell  [ROOT_W+1];

    // Register write decode
    assign cfg_ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                REG_CENTER_COL:    cfg_next.center_col    = cfg_data[COORD_W-1:0];
                REG_CENTER_ROW:    cfg_next.center_row    = cfg_data[COORD_W-1:0];
                REG_CIRCLE_RADIUS: cfg_next.circle_radius = cfg_data[RADIUS_W-1:0];
                REG_DRAW_RGB:      cfg_next.draw_rgb      = cfg_data[RGB_W-1:0];
                REG_SCREEN_COLS:   cfg_next.screen_cols   = cfg_data[DIM_W-1:0];
                REG_SCREEN_ROWS:   cfg_next.screen_rows   = cfg_data[DIM_W-1:0];
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.center_col    <= '0;
            cfg_reg.center_row    <= '0;
            cfg_reg.circle_radius <= '0;
            cfg_reg.draw_rgb      <= '0;
            cfg_reg.screen_cols   <= DIM_W'(4096);
            cfg_reg.screen_rows   <= DIM_W'(4096);
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // Offsets and squared distance
    acpb_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .pixel_col  (s_tdata[11:0]),
        .pixel_row  (s_tdata[23:12]),
        .fb_word    (s_tdata[55:24]),
        .out_valid  (chain_valid[0]),
        .out_ready  (chain_ready[0]),
        .out_cell   (chain_cell[0])
    );

    // Square-root chain, one cell per root bit
    for (genvar i = 0; i < ROOT_W; i++)
    begin : g_cell
        acpb_root_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (chain_valid[i]),
            .in_ready  (chain_ready[i]),
            .in_cell   (chain_cell[i]),
            .out_valid (chain_valid[i+1]),
            .out_ready (chain_ready[i+1]),
            .out_cell  (chain_cell[i+1])
        );
    end

    // Alpha and blend, output register
    acpb_blend u_blend (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg_reg),
        .in_valid      (chain_valid[ROOT_W]),
        .in_ready      (chain_ready[ROOT_W]),
        .in_cell       (chain_cell[ROOT_W]),
        .out_valid     (m_tvalid),
        .out_ready     (m_tready),
        .write_pixel   (m_tuser),
        .blended_color (m_tdata)
    );

endmodule

### design/acpb_front.sv
// ----------------------------------------------------------------------------
// acpb_front: offset, bounds check and squared distance
// Two register stages: absolute offsets from the center, then the squares.
// The sum of squares, shifted up by 2F, seeds the first root cell.
// ----------------------------------------------------------------------------
module acpb_front
    import acpb_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  acpb_cfg_t          cfg,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [COORD_W-1:0] pixel_col,
    input  logic [COORD_W-1:0] pixel_row,
    input  logic [COLOR_W-1:0] fb_word,
    output logic               out_valid,
    input  logic               out_ready,
    output acpb_cell_t         out_cell
);

    logic               a_valid_reg;
    logic               a_valid_next;
    logic [COORD_W-1:0] a_dx_reg;
    logic [COORD_W-1:0] a_dy_reg;
    acpb_tag_t          a_tag_reg;
    logic               a_ready;

    logic               b_valid_reg;
    logic               b_valid_next;
    logic [SQ_W-1:0]    b_sqx_reg;
    logic [SQ_W-1:0]    b_sqy_reg;
    acpb_tag_t          b_tag_reg;
    logic               b_ready;

    logic [COORD_W-1:0] dx;
    logic [COORD_W-1:0] dy;
    logic               on_screen;
    logic [D2_W-1:0]    d2;

    // Stage handshake: a stage takes new data when empty or draining
    assign b_ready  = !b_valid_reg || out_ready;
    assign a_ready  = !a_valid_reg || b_ready;
    assign in_ready = a_ready;

    assign a_valid_next = a_ready ? in_valid : a_valid_reg;
    assign b_valid_next = b_ready ? a_valid_reg : b_valid_reg;

    // Absolute offsets and screen bounds
    always_comb
    begin
        dx = (pixel_col >= cfg.center_col) ? pixel_col - cfg.center_col
                                           : cfg.center_col - pixel_col;
        dy = (pixel_row >= cfg.center_row) ? pixel_row - cfg.center_row
                                           : cfg.center_row - pixel_row;
        on_screen = ({1'b0, pixel_col} < cfg.screen_cols) &&
                    ({1'b0, pixel_row} < cfg.screen_rows);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end
        else
        begin
            a_valid_reg <= a_valid_next;
            b_valid_reg <= b_valid_next;
        end
    end

    // Hold payload while stalled
    always_ff @(posedge clk)
    begin
        if (a_ready && in_valid)
        begin
            a_dx_reg          <= dx;
            a_dy_reg          <= dy;
            a_tag_reg.on_screen <= on_screen;
            a_tag_reg.dst_rgb <= fb_word[RGB_W-1:0];
        end
        if (b_ready && a_valid_reg)
        begin
            b_sqx_reg <= SQ_W'(a_dx_reg) * SQ_W'(a_dx_reg);
            b_sqy_reg <= SQ_W'(a_dy_reg) * SQ_W'(a_dy_reg);
            b_tag_reg <= a_tag_reg;
        end
    end

    // Seed the first root cell
    assign d2 = D2_W'(b_sqx_reg) + D2_W'(b_sqy_reg);

    always_comb
    begin
        out_cell      = '0;
        out_cell.rad  = {{RAD_PAD_W{1'b0}}, d2, {(2 * FRAC_BITS){1'b0}}};
        out_cell.tag  = b_tag_reg;
    end

    assign out_valid = b_valid_reg;

endmodule

### design/acpb_root_cell.sv
// ----------------------------------------------------------------------------
// acpb_root_cell: one digit step of the integer square root
// Brings down two radicand bits, tries (root << 2) | 1 against the
// remainder and shifts one root bit in, then hands the state onward.
// ----------------------------------------------------------------------------
module acpb_root_cell
    import acpb_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  acpb_cell_t in_cell,
    output logic       out_valid,
    input  logic       out_ready,
    output acpb_cell_t out_cell
);

    logic       valid_reg;
    logic       valid_next;
    acpb_cell_t cell_reg;
    acpb_cell_t cell_next;
    logic [REM_W-1:0] rem_sh;
    logic [REM_W-1:0] trial;

    assign in_ready   = !valid_reg || out_ready;
    assign valid_next = in_ready ? in_valid : valid_reg;

    // One restoring step
    always_comb
    begin
        rem_sh = {in_cell.rem[REM_W-3:0], in_cell.rad[RAD_W-1 -: 2]};
        trial  = {in_cell.root, 2'b01};
        cell_next     = in_cell;
        cell_next.rad = {in_cell.rad[RAD_W-3:0], 2'b00};
        if (rem_sh >= trial)
        begin
            cell_next.rem  = rem_sh - trial;
            cell_next.root = {in_cell.root[ROOT_W-2:0], 1'b1};
        end
        else
        begin
            cell_next.rem  = rem_sh;
            cell_next.root = {in_cell.root[ROOT_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Hold state while stalled
    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            cell_reg <= cell_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_cell  = cell_reg;

    // Remainder never exceeds twice the partial root
    a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg |-> (cell_reg.rem <= {cell_reg.root, 1'b0}))
        else $error("root cell remainder out of bound");

endmodule

### design/acpb_blend.sv
// ----------------------------------------------------------------------------
// acpb_blend: coverage alpha and color blend
// First stage compares distance to radius and forms the clamped alpha;
// second stage blends each channel and holds the result for the output.
// ----------------------------------------------------------------------------
module acpb_blend
    import acpb_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  acpb_cfg_t          cfg,
    input  logic               in_valid,
    output logic               in_ready,
    input  acpb_cell_t         in_cell,
    output logic               out_valid,
    input  logic               out_ready,
    output logic               write_pixel,
    output logic [COLOR_W-1:0] blended_color
);

    localparam int PROD_W = 8 + ALPHA_W;
    localparam logic [ALPHA_W-1:0] ONE_A = ALPHA_W'(ONE_Q);

    logic               d_valid_reg;
    logic               d_valid_next;
    logic               d_write_reg;
    logic [ALPHA_W-1:0] d_alpha_reg;
    logic [RGB_W-1:0]   d_dst_reg;
    logic               d_ready;

    logic               e_valid_reg;
    logic               e_valid_next;
    logic               e_write_reg;
    logic [COLOR_W-1:0] e_color_reg;
    logic               e_ready;

    logic [CMP_W-1:0]   radial;
    logic [CMP_W-1:0]   rad_q;
    logic [CMP_W-1:0]   diff;
    logic               covered;
    logic [ALPHA_W-1:0] alpha;
    logic [COLOR_W-1:0] color;

    // Blend one channel, truncating
    function automatic logic [7:0] blend_chan(input logic [7:0] dst,
                                              input logic [7:0] src,
                                              input logic [ALPHA_W-1:0] a);
        logic [ALPHA_W-1:0] inv;
        logic [PROD_W-1:0]  sum;
        inv = ONE_A - a;
        sum = PROD_W'(dst) * PROD_W'(inv) + PROD_W'(src) * PROD_W'(a);
        return sum[FRAC_BITS +: 8];
    endfunction

    assign e_ready  = !e_valid_reg || out_ready;
    assign d_ready  = !d_valid_reg || e_ready;
    assign in_ready = d_ready;

    assign d_valid_next = d_ready ? in_valid : d_valid_reg;
    assign e_valid_next = e_ready ? d_valid_reg : e_valid_reg;

    // Distance test and clamped alpha
    always_comb
    begin
        radial  = CMP_W'(in_cell.root);
        rad_q   = CMP_W'({cfg.circle_radius, {FRAC_BITS{1'b0}}});
        covered = radial <= rad_q + CMP_W'(C06_Q);
        diff    = (radial >= rad_q) ? radial - rad_q : rad_q - radial;
        if (diff >= CMP_W'(C18_Q))
        begin
            alpha = '0;
        end
        else if (CMP_W'(C18_Q) - diff > CMP_W'(ONE_Q))
        begin
            alpha = ONE_A;
        end
        else
        begin
            alpha = ALPHA_W'(CMP_W'(C18_Q) - diff);
        end
    end

    // Per-channel blend; unwritten pixels return zero
    always_comb
    begin
        if (d_write_reg)
        begin
            color = {ALPHA_BYTE,
                     blend_chan(d_dst_reg[23:16], cfg.draw_rgb[23:16], d_alpha_reg),
                     blend_chan(d_dst_reg[15:8],  cfg.draw_rgb[15:8],  d_alpha_reg),
                     blend_chan(d_dst_reg[7:0],   cfg.draw_rgb[7:0],   d_alpha_reg)};
        end
        else
        begin
            color = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            d_valid_reg <= 1'b0;
            e_valid_reg <= 1'b0;
        end
        else
        begin
            d_valid_reg <= d_valid_next;
            e_valid_reg <= e_valid_next;
        end
    end

    // Hold payload while stalled
    always_ff @(posedge clk)
    begin
        if (d_ready && in_valid)
        begin
            d_write_reg <= in_cell.tag.on_screen && covered;
            d_alpha_reg <= alpha;
            d_dst_reg   <= in_cell.tag.dst_rgb;
        end
        if (e_ready && d_valid_reg)
        begin
            e_write_reg <= d_write_reg;
            e_color_reg <= color;
        end
    end

    assign out_valid     = e_valid_reg;
    assign write_pixel   = e_write_reg;
    assign blended_color = e_color_reg;

    a_no_write_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (e_valid_reg && !e_write_reg) |-> (e_color_reg == '0))
        else $error("unwritten pixel carries nonzero color");

    a_alpha_byte: assert property (@(posedge clk) disable iff (!rst_n)
        (e_valid_reg && e_write_reg) |-> (e_color_reg[31:24] == ALPHA_BYTE))
        else $error("written pixel lacks alpha byte");

    a_alpha_range: assert property (@(posedge clk) disable iff (!rst_n)
        d_valid_reg |-> (d_alpha_reg <= ONE_A))
        else $error("alpha above one");

endmodule
